### design/plst_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; used by the interfaces, the cell and the top level.
package plst_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 6;

  // Request action codes
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  // Result status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;   // insert: shift up from slot, load value at slot
    logic             del;   // delete: shift down from slot
    logic [POS_W-1:0] slot;  // zero-based target slot (position - 1)
  } plst_cmd_t;

endpackage

### design/plst_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on plst_pkg for field widths.
interface plst_req_if;
  import plst_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [POS_W-1:0]           position;
  logic signed [DATA_W-1:0]   value;
  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface plst_rsp_if;
  import plst_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic signed [DATA_W-1:0]   entry_out;
  logic [COUNT_W-1:0]         count;
  modport source (output valid, status, entry_out, count, input ready);
  modport sink   (input valid, status, entry_out, count, output ready);
endinterface

### design/positional_list_store_top.sv
// Positional list store: each accepted request is answered from the response
// register. Throughput: one transaction per cycle while responses are taken;
// every cell compares its index with the target slot and shifts in parallel.
// A new request is taken while a finished response waits, if it is taken.
// Reset clears the entry count and the response valid; entries are not
// cleared and hold their value until overwritten.
module positional_list_store_top #(
  parameter int CAPACITY = 32
) (
  input logic       clk,
  input logic       rst,
  plst_req_if.sink   req,
  plst_rsp_if.source rsp
);
  import plst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]          count_q;
  logic                      rsp_valid;
  logic                      rsp_status;
  logic signed [DATA_W-1:0]  rsp_entry;
  logic [COUNT_W-1:0]        rsp_count;

  logic                      accept;
  logic [POS_W-1:0]          slot;
  logic [EW-1:0]             slot_ext;
  logic [EW-1:0]             count_ext;
  logic                      pos_nonzero;
  logic                      in_list;
  logic                      in_append;
  logic                      is_full;
  logic                      op_ok;
  logic                      ins_ok;
  logic                      del_ok;
  logic signed [DATA_W-1:0]  rd_data;
  logic [CNT_W-1:0]          count_next;
  logic [EW-1:0]             count_next_ext;
  plst_cmd_t                 cmd;

  logic signed [DATA_W-1:0]  cell_q  [CAPACITY];
  logic signed [DATA_W-1:0]  cell_rd [CAPACITY];

  // Handshake: output register frees when empty or being taken
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Range checks
  assign slot        = req.position - POS_W'(1);
  assign slot_ext    = EW'(slot);
  assign count_ext   = EW'(count_q);
  assign pos_nonzero = (req.position != '0);
  assign in_list     = pos_nonzero && (slot_ext < count_ext);
  assign in_append   = pos_nonzero && (slot_ext <= count_ext);
  assign is_full     = (count_ext == EW'(CAPACITY));

  // Action decode
  always_comb begin
    op_ok  = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    unique case (req.action)
      ACT_READ:   op_ok = in_list;
      ACT_INSERT: begin
        op_ok  = in_append && !is_full;
        ins_ok = op_ok;
      end
      ACT_DELETE: begin
        op_ok  = in_list;
        del_ok = op_ok;
      end
      default:    op_ok = 1'b0;
    endcase
  end

  assign cmd.ins  = accept && ins_ok;
  assign cmd.del  = accept && del_ok;
  assign cmd.slot = slot;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    plst_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ins_value (req.value),
      .left_q    (left_v),
      .right_q   (right_v),
      .q         (cell_q[i]),
      .rd        (cell_rd[i])
    );
  end

  // Collect the addressed entry (one cell at most is nonzero)
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  // Count update
  always_comb begin
    count_next = count_q;
    if (ins_ok) begin
      count_next = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count_q - CNT_W'(1);
    end
  end
  assign count_next_ext = EW'(count_next);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= op_ok ? ST_DONE : ST_ERROR;
      rsp_entry  <= (op_ok && !ins_ok) ? rd_data : '0;
      rsp_count  <= count_next_ext[COUNT_W-1:0];
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.entry_out = rsp_entry;
  assign rsp.count     = rsp_count;

`ifndef SYNTHESIS
  // Count never exceeds the row length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    EW'(count_q) <= EW'(CAPACITY))
    else $error("entry count above capacity");

  // A successful insert grows the list by one
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not bump count");

  // A successful delete shrinks the list by one
  a_del_count: assert property (@(posedge clk) disable iff (rst)
    (accept && del_ok) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("delete did not drop count");

  // Error responses carry a zero entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == ST_ERROR) |-> (rsp_entry == '0))
    else $error("error response with nonzero entry");

  // Empty output register always takes a request
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req.ready)
    else $error("not ready with empty response register");
`endif

endmodule

### design/plst_cell.sv
// One storage cell of the list row: holds a single entry and shifts
// with its neighbors on insert and delete. Depends on plst_pkg.
module plst_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 5
) (
  input  logic                            clk,
  input  plst_pkg::plst_cmd_t             cmd,
  input  logic signed [plst_pkg::DATA_W-1:0] ins_value,
  input  logic signed [plst_pkg::DATA_W-1:0] left_q,
  input  logic signed [plst_pkg::DATA_W-1:0] right_q,
  output logic signed [plst_pkg::DATA_W-1:0] q,
  output logic signed [plst_pkg::DATA_W-1:0] rd
);
  import plst_pkg::*;

  localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;

  logic [CW-1:0] my_idx;
  logic [CW-1:0] slot_w;
  logic          at_slot;
  logic          past_slot;

  // Position compare against the broadcast slot
  assign my_idx    = CW'(IDX);
  assign slot_w    = CW'(cmd.slot);
  assign at_slot   = (slot_w == my_idx);
  assign past_slot = (my_idx > slot_w);

  // Entry register: shift up, load, or shift down
  always_ff @(posedge clk) begin
    if (cmd.ins && past_slot) begin
      q <= left_q;
    end else if (cmd.ins && at_slot) begin
      q <= ins_value;
    end else if (cmd.del && (at_slot || past_slot)) begin
      q <= right_q;
    end
  end

  // Read contribution: only the addressed cell drives nonzero
  assign rd = at_slot ? q : '0;

endmodule

### tb/tb_positional_list_store_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_store_top: a directed table,
// then shaped random requests. Depends on plst_pkg, plst_if and the top level.
module tb_positional_list_store_top;
  import plst_pkg::*;

  localparam int CAPACITY       = 32;
  localparam int ITEMS_PER_PASS = 534;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int TAIL_CYCLES    = 4;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]   VAL_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0]   VAL_MAX    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                      status;
    logic signed [DATA_W-1:0]  entry;
    logic [COUNT_W-1:0]        count;
  } list_reply_t;

  typedef struct packed {
    bit          typed;
    list_reply_t reply;
  } reply_hint_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   val;
    bit                  typed;
    list_reply_t         reply;
  } table_row_t;

  localparam int N_ROWS = 26;

  // Directed rows; typed replies only where obvious, the rest go to the predictor
  table_row_t dir_rows [N_ROWS] = '{
    '{ACT_READ,   6'd1,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd0}},
    '{ACT_DELETE, 6'd1,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd0}},
    '{ACT_INSERT, 6'd0,  32'd5,        1'b1, '{ST_ERROR, 32'd0,   6'd0}},
    '{ACT_INSERT, 6'd2,  32'd5,        1'b1, '{ST_ERROR, 32'd0,   6'd0}},
    '{ACT_UNUSED, 6'd1,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd0}},
    '{ACT_INSERT, 6'd1,  VAL_MAX,      1'b1, '{ST_DONE,  32'd0,   6'd1}},
    '{ACT_INSERT, 6'd1,  VAL_MIN,      1'b1, '{ST_DONE,  32'd0,   6'd2}},
    '{ACT_READ,   6'd1,  32'd0,        1'b1, '{ST_DONE,  VAL_MIN, 6'd2}},
    '{ACT_READ,   6'd2,  32'd0,        1'b1, '{ST_DONE,  VAL_MAX, 6'd2}},
    '{ACT_READ,   6'd3,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd2}},
    '{ACT_INSERT, 6'd3,  32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'd0,   6'd3}},
    '{ACT_READ,   6'd0,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd3}},
    '{ACT_INSERT, 6'd2,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_READ,   6'd63, 32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd4}},
    '{ACT_INSERT, 6'd63, 32'd7,        1'b1, '{ST_ERROR, 32'd0,   6'd4}},
    '{ACT_READ,   6'd3,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_DELETE, 6'd2,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_DELETE, 6'd0,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd3}},
    '{ACT_DELETE, 6'd4,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd3}},
    '{ACT_UNUSED, 6'd63, 32'hFFFF_FFFF, 1'b1, '{ST_ERROR, 32'd0,  6'd3}},
    '{ACT_DELETE, 6'd3,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_INSERT, 6'd2,  32'h5A5A_5A5A, 1'b0, '{ST_DONE, 32'd0,   6'd0}},
    '{ACT_DELETE, 6'd1,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_DELETE, 6'd2,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_DELETE, 6'd1,  32'd0,        1'b0, '{ST_DONE,  32'd0,   6'd0}},
    '{ACT_READ,   6'd1,  32'd0,        1'b1, '{ST_ERROR, 32'd0,   6'd0}}
  };

  logic clk = 1'b0;
  logic rst;

  plst_req_if req_ch ();
  plst_rsp_if rsp_ch ();

  positional_list_store_top #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  // Predictor state: list contents and length as of the last accepted request
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len = 0;

  // Length as seen by the request generator, advanced at issue time
  int plan_len = 0;
  bit filling  = 1'b1;

  list_reply_t reply_fifo [$];
  reply_hint_t hint_fifo  [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int pass_no     = 0;
  int hold_left   = 0;
  bit held_once   = 1'b0;

  int errors        = 0;
  int stall_cycles  = 0;
  int n_sent        = 0;
  int n_replies     = 0;
  int n_err_replies = 0;
  int n_full_reject = 0;
  int n_pressure    = 0;

  // Apply one request to the predicted list and return the expected reply
  function automatic list_reply_t list_apply(logic [ACTION_W-1:0] act,
                                             logic [POS_W-1:0] pos,
                                             logic signed [DATA_W-1:0] val);
    list_reply_t r;
    int          p;
    int          k;
    r.status = ST_ERROR;
    r.entry  = '0;
    p = pos;
    case (act)
      ACT_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.status = ST_DONE;
          r.entry  = list_mem[p-1];
        end
      end
      ACT_INSERT: begin
        if (list_len < CAPACITY && p >= 1 && p <= list_len + 1) begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
          r.status = ST_DONE;
        end
      end
      ACT_DELETE: begin
        if (list_len > 0 && p >= 1 && p <= list_len) begin
          r.entry = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // Track only the length, so the generator can aim at legal positions
  function automatic void plan_advance(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos);
    int p;
    p = pos;
    if (act == ACT_INSERT && plan_len < CAPACITY && p >= 1 && p <= plan_len + 1)
      plan_len++;
    else if (act == ACT_DELETE && plan_len > 0 && p >= 1 && p <= plan_len)
      plan_len--;
  endfunction

  // Offer one transaction, with random sender gaps, and wait for acceptance
  task automatic send_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] val, reply_hint_t hint);
    hint_fifo.push_back(hint);
    plan_advance(act, pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // Mostly legal requests that fill and drain the list; some noise
  task automatic pick_request(output logic [ACTION_W-1:0] act,
                              output logic [POS_W-1:0] pos,
                              output logic [DATA_W-1:0] val);
    int roll;
    int mix;
    if (filling && plan_len == CAPACITY && $urandom_range(3) == 0)
      filling = 1'b0;
    else if (!filling && plan_len == 0 && $urandom_range(3) == 0)
      filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < 12) begin
      case ($urandom_range(3))
        0: begin act = ACT_UNUSED; pos = POS_W'($urandom_range(63)); end
        1: begin act = ACTION_W'($urandom_range(2)); pos = '0; end
        2: begin
          act = ACTION_W'($urandom_range(2));
          pos = POS_W'($urandom_range(63));
        end
        default: begin
          act = ($urandom_range(1) == 0) ? ACT_READ : ACT_DELETE;
          pos = POS_W'(plan_len + 1);
        end
      endcase
    end else begin
      mix = $urandom_range(99);
      if (filling)
        act = (mix < 60) ? ACT_INSERT : (mix < 85) ? ACT_READ : ACT_DELETE;
      else
        act = (mix < 15) ? ACT_INSERT : (mix < 40) ? ACT_READ : ACT_DELETE;
      if (act == ACT_INSERT)
        pos = POS_W'($urandom_range(plan_len + 1, 1));
      else
        pos = (plan_len == 0) ? 6'd1 : POS_W'($urandom_range(plan_len, 1));
    end
    case ($urandom_range(15))
      0: val = VAL_MIN;
      1: val = VAL_MAX;
      2: val = '0;
      3: val = '1;
      default: val = $urandom();
    endcase
  endtask

  // Receiver: random ready, plus one long hold-off at the start of the last pass
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (pass_no == 2 && !held_once) begin
      held_once    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
      n_pressure   <= n_pressure + 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check replies in order, predict each accepted request
  always @(posedge clk) begin : monitor
    list_reply_t want;
    list_reply_t pred;
    reply_hint_t hint;
    bit          moved;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      moved = (rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready);
      stall_cycles <= moved ? 0 : stall_cycles + 1;
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_replies++;
        if (rsp_ch.status == ST_ERROR) n_err_replies++;
        if (reply_fifo.size() == 0) begin
          $display("%0t: unexpected reply status=%0d entry=%0d count=%0d",
                   $time, rsp_ch.status, rsp_ch.entry_out, rsp_ch.count);
          errors++;
        end else begin
          want = reply_fifo.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.entry_out !== want.entry ||
              rsp_ch.count !== want.count) begin
            $display("%0t: mismatch expected status=%0d entry=%0d count=%0d, %s",
                     $time, want.status, want.entry, want.count, "got");
            $display("%0t:          actual   status=%0d entry=%0d count=%0d",
                     $time, rsp_ch.status, rsp_ch.entry_out, rsp_ch.count);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = list_apply(req_ch.action, req_ch.position, req_ch.value);
        if (req_ch.action == ACT_INSERT && pred.status == ST_ERROR &&
            list_len == CAPACITY)
          n_full_reject++;
        hint = (hint_fifo.size() != 0) ? hint_fifo.pop_front() : '0;
        reply_fifo.push_back(hint.typed ? hint.reply : pred);
      end
    end
  end

  // Watchdog: no transaction on either channel for too long
  initial begin
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("positional_list_store_top test failed");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   val;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_READ;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, under light random gaps
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].pos, dir_rows[i].val,
                   '{dir_rows[i].typed, dir_rows[i].reply});

    // three random passes: receiver-heavy gaps, sender-heavy gaps, none
    for (int p = 0; p < 3; p++) begin
      pass_no     = p;
      tx_idle_pct = (p == 0) ? 30 : (p == 1) ? 79 : 0;
      rx_idle_pct = (p == 0) ? 79 : (p == 1) ? 30 : 0;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        pick_request(act, pos, val);
        send_request(act, pos, val, '0);
      end
    end
    req_ch.valid <= 1'b0;

    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d replies (%0d errors), %0d inserts refused when full,",
             n_sent, n_replies, n_err_replies, n_full_reject);
    $display("  %0d long output hold-off(s), with and without idle cycles on both sides",
             n_pressure);
    if (errors == 0 && reply_fifo.size() == 0)
      $display("positional_list_store_top test passed");
    else
      $display("positional_list_store_top test failed");
    $finish;
  end

endmodule
